// ===== hw/rtl/gcp_pkg.sv =====
// Shared constants, types and helper functions of the splat covariance and colour pipeline.
package gcp_pkg;

	localparam int QUAT_W    = 16;
	localparam int SCALE_W   = 24;
	localparam int COLOR_W   = 17;
	localparam int COV_W     = 48;
	localparam int N_W       = 33;
	localparam int PMAG_W    = 33;
	localparam int DIVD_W    = 63;
	localparam int DIV_STEPS = 31;
	localparam int RMAG_W    = 31;
	localparam int MMAG_W    = 33;
	localparam int PROD_W    = 66;
	localparam int LAT       = DIV_STEPS + 5;

	localparam logic [COLOR_W-1:0] COLOR_ONE = 17'd65536;

	typedef struct packed {
		logic [31:0]                 rgba;
		logic [2:0][SCALE_W-1:0]     scale;
		logic                        zero;
		logic [8:0]                  neg;
	} side_t;

	// Saturate a Q1.16 intensity to one and round it to eight bits.
	function automatic logic [7:0] color_byte(input logic [COLOR_W-1:0] c);
		logic [COLOR_W-1:0] cs;
		logic [24:0]        t;
		cs = (c > COLOR_ONE) ? COLOR_ONE : c;
		t  = 25'(cs) * 25'd255 + 25'd32768;
		return t[23:16];
	endfunction

	// Row index of each upper-triangle covariance entry.
	function automatic logic [1:0] pair_row(input int e);
		logic [1:0] r;
		case (e)
			0, 1, 2: r = 2'd0;
			3, 4:    r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	// Column index of each upper-triangle covariance entry.
	function automatic logic [1:0] pair_col(input int e);
		logic [1:0] c;
		case (e)
			0:       c = 2'd0;
			1, 3:    c = 2'd1;
			default: c = 2'd2;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/gcp_if.sv =====
// Request channels: splat input and packed result output.
interface gcp_in_if;
	logic                 valid;
	logic                 ready;
	logic signed [15:0]   quat_w;
	logic signed [15:0]   quat_x;
	logic signed [15:0]   quat_y;
	logic signed [15:0]   quat_z;
	logic [23:0]          scale_x;
	logic [23:0]          scale_y;
	logic [23:0]          scale_z;
	logic [16:0]          red;
	logic [16:0]          green;
	logic [16:0]          blue;
	logic [16:0]          alpha;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
		red, green, blue, alpha, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z,
		red, green, blue, alpha, output ready);
endinterface

interface gcp_out_if;
	logic                 valid;
	logic                 ready;
	logic [31:0]          packed_rgba;
	logic signed [47:0]   cov_xx;
	logic signed [47:0]   cov_xy;
	logic signed [47:0]   cov_xz;
	logic signed [47:0]   cov_yy;
	logic signed [47:0]   cov_yz;
	logic signed [47:0]   cov_zz;

	modport source (output valid, packed_rgba, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
		input ready);
	modport sink (input valid, packed_rgba, cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz,
		output ready);
endinterface

// ===== hw/rtl/gcp_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module gcp_div (
	input  logic                                clk,
	input  logic                                en,
	input  logic [gcp_pkg::DIVD_W-1:0]          dividend,
	input  logic [gcp_pkg::N_W-1:0]             divisor,
	output logic [gcp_pkg::RMAG_W-1:0]          quotient
);
	localparam int STEPS = gcp_pkg::DIV_STEPS;

	logic [gcp_pkg::N_W-1:0]    rem_s [0:STEPS];
	logic [STEPS-1:0]           num_s [0:STEPS];
	logic [STEPS-1:0]           quo_s [0:STEPS];
	logic [gcp_pkg::N_W-1:0]    den_s [0:STEPS];

	// Upper dividend bits already lie below the divisor.
	assign rem_s[0] = gcp_pkg::N_W'(dividend[gcp_pkg::DIVD_W-1:STEPS]);
	assign num_s[0] = dividend[STEPS-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = divisor;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [gcp_pkg::N_W:0] trial;
		logic                  ge;

		// Shift in the next dividend bit and subtract where it fits.
		always_comb begin
			trial = {rem_s[k], num_s[k][STEPS-1]};
			ge    = trial >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? gcp_pkg::N_W'(trial - {1'b0, den_s[k]})
					: gcp_pkg::N_W'(trial);
				num_s[k+1] <= num_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][STEPS-2:0], ge};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quotient = quo_s[STEPS];
endmodule

// ===== hw/rtl/gcp_cov.sv =====
// Scaled rotation, pairwise products and rounded, saturated covariance sums.
module gcp_cov (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic [8:0][gcp_pkg::RMAG_W-1:0]         rmag,
	input  logic [8:0]                              rneg,
	input  logic                                    zero,
	input  logic [2:0][gcp_pkg::SCALE_W-1:0]        scale,
	output logic [5:0][gcp_pkg::COV_W-1:0]          cov
);
	localparam int SUM_W = gcp_pkg::PROD_W + 3;
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(48'h7FFF_FFFF_FFFF);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	logic [8:0][gcp_pkg::MMAG_W-1:0]               mmag_s3;
	logic [8:0]                                    mneg_s3;
	logic signed [gcp_pkg::PROD_W:0]               prod_s4 [6][3];

	// Stage 3: M = R * diag(scale), rounded to Q8.24; identity for a zero quaternion.
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar k = 0; k < 3; k++) begin : g_col
			logic [gcp_pkg::RMAG_W-1:0] r;
			logic [54:0]                t;
			always_comb begin
				if (zero) begin
					r = (i == k) ? gcp_pkg::RMAG_W'(1 << 30) : '0;
				end else begin
					r = rmag[i*3+k];
				end
				t = 55'(r) * 55'(scale[k]) + 55'(1 << 21);
			end
			always_ff @(posedge clk) begin
				if (en) begin
					mmag_s3[i*3+k] <= t[54:22];
					mneg_s3[i*3+k] <= rneg[i*3+k] && !zero;
				end
			end
		end
	end

	// Stage 4: signed products of matching row terms.
	for (genvar e = 0; e < 6; e++) begin : g_ent
		localparam int PI = int'(gcp_pkg::pair_row(e));
		localparam int PJ = int'(gcp_pkg::pair_col(e));
		logic signed [SUM_W-1:0] sum;
		logic signed [SUM_W-1:0] rnd;

		for (genvar k = 0; k < 3; k++) begin : g_term
			logic [gcp_pkg::PROD_W-1:0] p;
			assign p = gcp_pkg::PROD_W'(mmag_s3[PI*3+k]) * gcp_pkg::PROD_W'(mmag_s3[PJ*3+k]);
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s4[e][k] <= (mneg_s3[PI*3+k] != mneg_s3[PJ*3+k])
						? -$signed({1'b0, p}) : $signed({1'b0, p});
				end
			end
		end

		// Stage 5: exact sum, drop 16 bits with ties upward, saturate to 48 bits.
		always_comb begin
			sum = SUM_W'(prod_s4[e][0]) + SUM_W'(prod_s4[e][1]) + SUM_W'(prod_s4[e][2])
				+ SUM_W'(32768);
			rnd = sum >>> 16;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rnd > SAT_HI) begin
					cov[e] <= SAT_HI[gcp_pkg::COV_W-1:0];
				end else if (rnd < SAT_LO) begin
					cov[e] <= SAT_LO[gcp_pkg::COV_W-1:0];
				end else begin
					cov[e] <= rnd[gcp_pkg::COV_W-1:0];
				end
			end
		end
	end
endmodule

// ===== hw/rtl/gaussian_covariance_and_color_pack.sv =====
// Top level: quaternion normalisation, covariance pipeline and colour packing.
// Throughput: one splat per cycle while no result waits at the output;
// the 31-stage quotient pipeline sets the depth.
// The whole pipeline halts together while the output register holds an untaken result.
// Reset (arst_n low) clears all valid bits at once; payload registers are not reset.
module gaussian_covariance_and_color_pack (
	input  logic        clk,
	input  logic        arst_n,
	gcp_in_if.sink      splat,
	gcp_out_if.source   result
);
	localparam int LAT   = gcp_pkg::LAT;
	localparam int STEPS = gcp_pkg::DIV_STEPS;

	logic                                    en;
	logic [LAT-1:0]                          vld_q;

	logic signed [31:0]                      ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [31:0]                      xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic [2:0][gcp_pkg::SCALE_W-1:0]        scale_s1;
	logic [31:0]                             rgba_s1;

	logic [gcp_pkg::N_W-1:0]                 n_c;
	logic signed [gcp_pkg::PMAG_W:0]         p_c [9];
	logic [gcp_pkg::N_W-1:0]                 n_s2;
	logic [gcp_pkg::DIVD_W-1:0]              divd_s2 [9];
	gcp_pkg::side_t                          side_s2;
	gcp_pkg::side_t                          side_sd [1:STEPS];
	logic [8:0][gcp_pkg::RMAG_W-1:0]         quo;
	logic [31:0]                             rgba_s3, rgba_s4, rgba_s5;
	logic [5:0][gcp_pkg::COV_W-1:0]          cov;

	// Whole-pipeline advance: only a waiting result holds it.
	assign en          = !vld_q[LAT-1] || result.ready;
	assign splat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], splat.valid};
		end
	end

	// Stage 1: quadratic quaternion terms, packed colour.
	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= splat.quat_w * splat.quat_w;
			xx_s1 <= splat.quat_x * splat.quat_x;
			yy_s1 <= splat.quat_y * splat.quat_y;
			zz_s1 <= splat.quat_z * splat.quat_z;
			xy_s1 <= splat.quat_x * splat.quat_y;
			xz_s1 <= splat.quat_x * splat.quat_z;
			yz_s1 <= splat.quat_y * splat.quat_z;
			wx_s1 <= splat.quat_w * splat.quat_x;
			wy_s1 <= splat.quat_w * splat.quat_y;
			wz_s1 <= splat.quat_w * splat.quat_z;
			scale_s1 <= {splat.scale_z, splat.scale_y, splat.scale_x};
			rgba_s1  <= {gcp_pkg::color_byte(splat.alpha), gcp_pkg::color_byte(splat.blue),
				gcp_pkg::color_byte(splat.green), gcp_pkg::color_byte(splat.red)};
		end
	end

	// Stage 2: norm and the unnormalised rotation matrix n * R.
	always_comb begin
		n_c = {1'b0, ww_s1} + {1'b0, xx_s1} + {1'b0, yy_s1} + {1'b0, zz_s1};
		p_c[0] = 34'(ww_s1) + 34'(xx_s1) - 34'(yy_s1) - 34'(zz_s1);
		p_c[1] = (34'(xy_s1) - 34'(wz_s1)) <<< 1;
		p_c[2] = (34'(xz_s1) + 34'(wy_s1)) <<< 1;
		p_c[3] = (34'(xy_s1) + 34'(wz_s1)) <<< 1;
		p_c[4] = 34'(ww_s1) - 34'(xx_s1) + 34'(yy_s1) - 34'(zz_s1);
		p_c[5] = (34'(yz_s1) - 34'(wx_s1)) <<< 1;
		p_c[6] = (34'(xz_s1) - 34'(wy_s1)) <<< 1;
		p_c[7] = (34'(yz_s1) + 34'(wx_s1)) <<< 1;
		p_c[8] = 34'(ww_s1) - 34'(xx_s1) - 34'(yy_s1) + 34'(zz_s1);
	end

	for (genvar l = 0; l < 9; l++) begin : g_lane
		logic [gcp_pkg::PMAG_W-1:0] mag;
		assign mag = p_c[l][gcp_pkg::PMAG_W] ? gcp_pkg::PMAG_W'(-p_c[l])
			: gcp_pkg::PMAG_W'(p_c[l]);

		// Dividend for round-half-away quotient of |P| * 2^30 / n.
		always_ff @(posedge clk) begin
			if (en) begin
				divd_s2[l] <= (gcp_pkg::DIVD_W'(mag) << 30) + gcp_pkg::DIVD_W'(n_c >> 1);
			end
		end

		gcp_div u_div (
			.clk      (clk),
			.en       (en),
			.dividend (divd_s2[l]),
			.divisor  (n_s2),
			.quotient (quo[l])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2          <= n_c;
			side_s2.rgba  <= rgba_s1;
			side_s2.scale <= scale_s1;
			side_s2.zero  <= (n_c == '0);
			for (int l = 0; l < 9; l++) begin
				side_s2.neg[l] <= p_c[l][gcp_pkg::PMAG_W];
			end
		end
	end

	// Side data travels alongside the quotient stages.
	always_ff @(posedge clk) begin
		if (en) begin
			side_sd[1] <= side_s2;
			for (int k = 2; k <= STEPS; k++) begin
				side_sd[k] <= side_sd[k-1];
			end
			rgba_s3 <= side_sd[STEPS].rgba;
			rgba_s4 <= rgba_s3;
			rgba_s5 <= rgba_s4;
		end
	end

	gcp_cov u_cov (
		.clk   (clk),
		.en    (en),
		.rmag  (quo),
		.rneg  (side_sd[STEPS].neg),
		.zero  (side_sd[STEPS].zero),
		.scale (side_sd[STEPS].scale),
		.cov   (cov)
	);

	assign result.valid       = vld_q[LAT-1];
	assign result.packed_rgba = rgba_s5;
	assign result.cov_xx      = cov[0];
	assign result.cov_xy      = cov[1];
	assign result.cov_xz      = cov[2];
	assign result.cov_yy      = cov[3];
	assign result.cov_yz      = cov[4];
	assign result.cov_zz      = cov[5];

`ifndef SYNTHESIS
	// Diagonal covariance entries are sums of squares and never negative.
	a_diag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!cov[0][47] && !cov[3][47] && !cov[5][47]))
		else $error("negative diagonal covariance entry");

	// An accepted request occupies the first pipeline slot.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(splat.valid && splat.ready) |=> vld_q[0])
		else $error("accepted request lost at pipeline entry");

	// A stalled pipeline keeps every valid bit in place.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during a stall");
`endif
endmodule
